// ===== src/iat_pkg.sv =====
// Shared constants, command/status structs for the autocorrelation time block.
// No dependencies; every other file imports this package.
package iat_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 32;
  localparam int SUM_W       = SAMPLE_W + CNT_W - 1;
  localparam int MEAN_W      = SAMPLE_W + 1;
  localparam int DEV_W       = SAMPLE_W + 2;
  localparam int MAG_W       = 32;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int ACC_W       = 80;
  localparam int FRAC_W      = 16;
  localparam int QUO_W       = 18;
  localparam int NUM_W       = ACC_W + CNT_W;
  localparam int REM_W       = NUM_W + QUO_W - 1;
  localparam int MDIV_CNT_W  = 6;
  localparam int RDIV_CNT_W  = 5;
  localparam int LAG_W       = 9;
  localparam int TAU_W       = 27;
  localparam int TAU_OUT_W   = 26;
  localparam int STOP_W      = 9;
  localparam int WF_W        = 4;
  localparam int WIN_W       = TAU_W + WF_W;

  localparam logic [TAU_W-1:0] TAU_HALF = TAU_W'(32768);
  localparam logic [TAU_W-1:0] TAU_CAP  = TAU_W'(33554432);
  localparam logic [WF_W-1:0]  WF_RESET = WF_W'(6);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_WF_IDX = 1'b0;

  typedef struct packed {
    logic mean_start;
    logic lag_clear;
    logic lag_issue;
    logic a0_save;
    logic t_init;
    logic t_inc;
    logic stop_set;
    logic ratio_start;
    logic tau_add;
    logic series_clear;
  } iat_cmd_t;

  typedef struct packed {
    logic mean_busy;
    logic issue_last;
    logic pipe_empty;
    logic acc_pos;
    logic var_ok;
    logic has_lags;
    logic more_lags;
    logic t_zero;
    logic ratio_busy;
    logic win_stop;
  } iat_sts_t;

endpackage

// ===== src/iat_sample_if.sv =====
// Input channel: one series sample per item plus the closing flag.
// Depends on iat_pkg.
interface iat_sample_if import iat_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       is_last;

  modport source (output valid, output sample_value, output is_last, input ready);
  modport sink   (input valid, input sample_value, input is_last, output ready);
endinterface

// ===== src/iat_result_if.sv =====
// Output channel: one result item per closed series.
// Depends on iat_pkg.
interface iat_result_if import iat_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TAU_OUT_W-1:0] tau_value;
  logic [STOP_W-1:0]    stop_lag;
  logic                 zero_variance;

  modport source (output valid, output tau_value, output stop_lag, output zero_variance,
                  input ready);
  modport sink   (input valid, input tau_value, input stop_lag, input zero_variance,
                  output ready);
endinterface

// ===== src/iat_ratio.sv =====
// Serial ratio unit: (at * n * 2^16) / (a0 * nt), shift-add multiply then
// restoring divide, one step per cycle. Depends on iat_pkg.
module iat_ratio import iat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] at_i,
  input  logic [ACC_W-1:0] a0_i,
  input  logic [CNT_W-1:0] n_i,
  input  logic [CNT_W-1:0] nt_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quo_o
);

  logic                  busy_q, div_q;
  logic [RDIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]      mca_q, mcb_q, num_q, den_q;
  logic [CNT_W-1:0]      mpa_q, mpb_q;
  logic [REM_W-1:0]      rem_q, dsh_q;
  logic [QUO_W-1:0]      quo_q;
  logic [NUM_W-1:0]      num_nx, den_nx;
  logic                  ge;

  always_comb begin
    num_nx = mpa_q[0] ? num_q + mca_q : num_q;
    den_nx = mpb_q[0] ? den_q + mcb_q : den_q;
    ge     = rem_q >= dsh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      div_q  <= 1'b0;
      cnt_q  <= RDIV_CNT_W'(CNT_W - 1);
    end else if (busy_q) begin
      if (!div_q) begin
        if (cnt_q == '0) begin
          div_q <= 1'b1;
          cnt_q <= RDIV_CNT_W'(QUO_W - 1);
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end else if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mca_q <= NUM_W'(at_i);
      mcb_q <= NUM_W'(a0_i);
      mpa_q <= n_i;
      mpb_q <= nt_i;
      num_q <= '0;
      den_q <= '0;
      quo_q <= '0;
    end else if (busy_q && !div_q) begin
      // accumulate one multiplier bit of each product
      num_q <= num_nx;
      den_q <= den_nx;
      mca_q <= mca_q << 1;
      mcb_q <= mcb_q << 1;
      mpa_q <= mpa_q >> 1;
      mpb_q <= mpb_q >> 1;
      if (cnt_q == '0) begin
        rem_q <= REM_W'({num_nx, {FRAC_W{1'b0}}});
        dsh_q <= REM_W'(den_nx) << (QUO_W - 1);
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== src/iat_datapath.sv =====
// Datapath: sample memory, running sum, mean divider, lag product pipeline,
// tau accumulation. Driven by iat_ctrl commands; depends on iat_pkg, iat_ratio.
module iat_datapath import iat_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [WF_W-1:0]     wf_i,
  input  iat_cmd_t            cmd_i,
  output iat_sts_t            sts_o,
  output logic [TAU_OUT_W-1:0] tau_o,
  output logic [STOP_W-1:0]   stop_o,
  output logic                zero_var_o
);

  logic [SAMPLE_W-1:0] mem_q [MAX_SAMPLES];
  logic [CNT_W-1:0]    count_q;
  logic [SUM_W-1:0]    sum_q;

  // mean divider
  logic                  mdiv_busy_q, mdiv_neg_q;
  logic [MDIV_CNT_W-1:0] mdiv_cnt_q;
  logic [SUM_W-1:0]      mdiv_quo_q;
  logic [CNT_W-1:0]      mdiv_rem_q;
  logic [CNT_W:0]        mdiv_sh;
  logic                  mdiv_ge;
  logic [MEAN_W-1:0]     mdiv_q33;
  logic signed [MEAN_W-1:0] mean_q;

  // lag pipeline
  logic [ADDR_W-1:0]   i_q;
  logic [LAG_W-1:0]    t_q;
  logic [ADDR_W-1:0]   addr_b;
  logic                v1_q, v2_q, v3_q;
  logic [SAMPLE_W-1:0] rd_a_q, rd_b_q;
  logic signed [DEV_W-1:0] dev_a, dev_b;
  logic [DEV_W-1:0]    abs_a, abs_b;
  logic [MAG_W-1:0]    mag_a_q, mag_b_q;
  logic                neg2_q, neg3_q;
  logic [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0] acc_q, a0_q, term;
  logic                var_ok_q;

  // tau and stop lag
  logic [TAU_W-1:0]  tau_q;
  logic [STOP_W-1:0] stop_q;
  logic              ratio_busy;
  logic [QUO_W-1:0]  ratio_quo;
  logic [CNT_W-1:0]  n_minus_t;
  logic [WIN_W-1:0]  win_lhs, win_rhs;

  // sample load and lag operand reads
  always_ff @(posedge clk_i) begin
    if (load_i && !count_q[CNT_W-1]) begin
      mem_q[count_q[ADDR_W-1:0]] <= sample_i;
    end
    if (cmd_i.lag_issue) begin
      rd_a_q <= mem_q[i_q];
      rd_b_q <= mem_q[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else if (cmd_i.series_clear) begin
      count_q <= '0;
      sum_q   <= '0;
    end else if (load_i && !count_q[CNT_W-1]) begin
      count_q <= count_q + 1'b1;
      sum_q   <= sum_q + SUM_W'(signed'(sample_i));
    end
  end

  // mean = floor(sum / n), restoring divide on the magnitude
  always_comb begin
    mdiv_sh  = {mdiv_rem_q, mdiv_quo_q[SUM_W-1]};
    mdiv_ge  = mdiv_sh >= {1'b0, count_q};
    mdiv_q33 = {1'b0, mdiv_quo_q[MEAN_W-2:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mdiv_busy_q <= 1'b0;
      mdiv_cnt_q  <= '0;
    end else if (cmd_i.mean_start) begin
      mdiv_busy_q <= 1'b1;
      mdiv_cnt_q  <= MDIV_CNT_W'(SUM_W);
    end else if (mdiv_busy_q) begin
      if (mdiv_cnt_q == '0) begin
        mdiv_busy_q <= 1'b0;
      end else begin
        mdiv_cnt_q <= mdiv_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_start) begin
      mdiv_neg_q <= sum_q[SUM_W-1];
      mdiv_quo_q <= sum_q[SUM_W-1] ? -sum_q : sum_q;
      mdiv_rem_q <= '0;
    end else if (mdiv_busy_q) begin
      if (mdiv_cnt_q != '0) begin
        mdiv_rem_q <= mdiv_ge ? CNT_W'(mdiv_sh - {1'b0, count_q}) : CNT_W'(mdiv_sh);
        mdiv_quo_q <= {mdiv_quo_q[SUM_W-2:0], mdiv_ge};
      end else if (mdiv_neg_q) begin
        // round toward minus infinity for a negative sum
        mean_q <= -signed'(mdiv_q33 + MEAN_W'(mdiv_rem_q != '0));
      end else begin
        mean_q <= signed'(mdiv_q33);
      end
    end
  end

  // lag index and issue counter
  assign addr_b    = i_q + ADDR_W'(t_q);
  assign n_minus_t = count_q - CNT_W'(t_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      t_q <= '0;
    end else begin
      if (cmd_i.lag_clear) begin
        i_q <= '0;
      end else if (cmd_i.lag_issue) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.mean_start) begin
        t_q <= '0;
      end else if (cmd_i.t_init) begin
        t_q <= LAG_W'(1);
      end else if (cmd_i.t_inc) begin
        t_q <= t_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.lag_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    dev_a = DEV_W'(signed'(rd_a_q)) - DEV_W'(mean_q);
    dev_b = DEV_W'(signed'(rd_b_q)) - DEV_W'(mean_q);
    abs_a = dev_a[DEV_W-1] ? -dev_a : dev_a;
    abs_b = dev_b[DEV_W-1] ? -dev_b : dev_b;
    term  = neg3_q ? -signed'(ACC_W'(prod_q)) : signed'(ACC_W'(prod_q));
  end

  always_ff @(posedge clk_i) begin
    mag_a_q <= abs_a[MAG_W-1:0];
    mag_b_q <= abs_b[MAG_W-1:0];
    neg2_q  <= dev_a[DEV_W-1] ^ dev_b[DEV_W-1];
    prod_q  <= PROD_W'(mag_a_q) * PROD_W'(mag_b_q);
    neg3_q  <= neg2_q;
    if (cmd_i.lag_clear) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + term;
    end
    if (cmd_i.a0_save) begin
      a0_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_ok_q <= 1'b0;
    end else if (cmd_i.a0_save) begin
      var_ok_q <= sts_o.acc_pos;
    end
  end

  iat_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.ratio_start),
    .at_i    (acc_q),
    .a0_i    (a0_q),
    .n_i     (count_q),
    .nt_i    (n_minus_t),
    .busy_o  (ratio_busy),
    .quo_o   (ratio_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_start) begin
      tau_q  <= TAU_HALF;
      stop_q <= '0;
    end else begin
      if (cmd_i.tau_add) begin
        tau_q <= tau_q + TAU_W'(ratio_quo);
      end
      if (cmd_i.stop_set) begin
        stop_q <= STOP_W'(t_q);
      end
    end
  end

  assign win_lhs = WIN_W'({t_q, {FRAC_W{1'b0}}});
  assign win_rhs = WIN_W'(wf_i) * WIN_W'(tau_q);

  always_comb begin
    sts_o.mean_busy  = mdiv_busy_q;
    sts_o.issue_last = {1'b0, i_q} == (n_minus_t - 1'b1);
    sts_o.pipe_empty = !v1_q && !v2_q && !v3_q;
    sts_o.acc_pos    = !acc_q[ACC_W-1] && (acc_q != '0);
    sts_o.var_ok     = var_ok_q;
    sts_o.has_lags   = count_q[CNT_W-1:1] > (CNT_W-1)'(1);
    sts_o.more_lags  = ((CNT_W-1)'(t_q) + 1'b1) < count_q[CNT_W-1:1];
    sts_o.t_zero     = t_q == '0;
    sts_o.ratio_busy = ratio_busy;
    sts_o.win_stop   = win_lhs > win_rhs;
  end

  assign tau_o      = (tau_q > TAU_CAP) ? TAU_CAP[TAU_OUT_W-1:0] : tau_q[TAU_OUT_W-1:0];
  assign stop_o     = stop_q;
  assign zero_var_o = !var_ok_q;

endmodule

// ===== src/iat_ctrl.sv =====
// Sequencer for load, mean, per-lag sums, ratio and window test.
// Depends on iat_pkg; drives iat_datapath through iat_cmd_t.
module iat_ctrl import iat_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  input  logic     out_free_i,
  input  iat_sts_t sts_i,
  output iat_cmd_t cmd_o,
  output logic     in_ready_o,
  output logic     out_load_o
);

  localparam logic [3:0] S_LOAD       = 4'd0;
  localparam logic [3:0] S_MEAN_GO    = 4'd1;
  localparam logic [3:0] S_MEAN_WAIT  = 4'd2;
  localparam logic [3:0] S_LAG_START  = 4'd3;
  localparam logic [3:0] S_ISSUE      = 4'd4;
  localparam logic [3:0] S_DRAIN      = 4'd5;
  localparam logic [3:0] S_EVAL0      = 4'd6;
  localparam logic [3:0] S_EVAL       = 4'd7;
  localparam logic [3:0] S_RATIO_GO   = 4'd8;
  localparam logic [3:0] S_RATIO_WAIT = 4'd9;
  localparam logic [3:0] S_WIN        = 4'd10;
  localparam logic [3:0] S_FINISH     = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_last_i) begin
          state_d = S_MEAN_GO;
        end
      end
      S_MEAN_GO: begin
        cmd_o.mean_start = 1'b1;
        state_d          = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (!sts_i.mean_busy) begin
          state_d = S_LAG_START;
        end
      end
      S_LAG_START: begin
        cmd_o.lag_clear = 1'b1;
        state_d         = S_ISSUE;
      end
      S_ISSUE: begin
        cmd_o.lag_issue = 1'b1;
        if (sts_i.issue_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = sts_i.t_zero ? S_EVAL0 : S_EVAL;
        end
      end
      S_EVAL0: begin
        cmd_o.a0_save = 1'b1;
        if (sts_i.has_lags) begin
          cmd_o.t_init = 1'b1;
          // no variance: close at lag one without summing
          state_d = sts_i.acc_pos ? S_LAG_START : S_EVAL;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_EVAL: begin
        cmd_o.stop_set = 1'b1;
        state_d = (sts_i.var_ok && sts_i.acc_pos) ? S_RATIO_GO : S_FINISH;
      end
      S_RATIO_GO: begin
        cmd_o.ratio_start = 1'b1;
        state_d           = S_RATIO_WAIT;
      end
      S_RATIO_WAIT: begin
        if (!sts_i.ratio_busy) begin
          cmd_o.tau_add = 1'b1;
          state_d       = S_WIN;
        end
      end
      S_WIN: begin
        if (sts_i.win_stop || !sts_i.more_lags) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.t_inc = 1'b1;
          state_d     = S_LAG_START;
        end
      end
      S_FINISH: begin
        if (out_free_i) begin
          out_load_o         = 1'b1;
          cmd_o.series_clear = 1'b1;
          state_d            = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/integrated_autocorrelation_time_unit.sv =====
// Integrated autocorrelation time unit: top level with config register and result register.
// Samples load at one item per cycle while the sequencer is loading. After the closing item,
// the mean divider runs, then for each lag t examined (lag zero included) its N-t products
// pass through the product pipeline and its evaluation, with a serial ratio and window test
// for each lag that adds to tau; the result register loads once the output is free. Intake holds meanwhile.
// Reset clears the sample count, the running sum and the state; window_factor resets to 6.
module integrated_autocorrelation_time_unit import iat_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  iat_sample_if.sink            sample_i,
  iat_result_if.source          result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WF_W-1:0]      wf_q;
  iat_cmd_t             cmd;
  iat_sts_t             sts;
  logic                 in_ready, load, out_load, out_free;
  logic [TAU_OUT_W-1:0] tau_w;
  logic [STOP_W-1:0]    stop_w;
  logic                 zero_var_w;

  logic                 out_valid_q;
  logic [TAU_OUT_W-1:0] out_tau_q;
  logic [STOP_W-1:0]    out_stop_q;
  logic                 out_zero_q;

  // Config port: register index sits in paddr above the byte offset.
  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_WF_IDX) ? APB_DATA_W'(wf_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wf_q <= WF_RESET;
    end else if (psel && penable && pwrite && paddr[APB_ADDR_W-1] == REG_WF_IDX) begin
      wf_q <= pwdata[WF_W-1:0];
    end
  end

  // Accept samples only while the sequencer is loading.
  assign sample_i.ready = in_ready;
  assign load           = sample_i.valid && in_ready;

  // A finished result waits here; the next series may load meanwhile.
  assign out_free = !out_valid_q || result_o.ready;

  iat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_last_i  (sample_i.is_last),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready),
    .out_load_o (out_load)
  );

  iat_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .sample_i   (sample_i.sample_value),
    .wf_i       (wf_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .tau_o      (tau_w),
    .stop_o     (stop_w),
    .zero_var_o (zero_var_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_tau_q  <= tau_w;
      out_stop_q <= stop_w;
      out_zero_q <= zero_var_w;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.tau_value     = out_tau_q;
  assign result_o.stop_lag      = out_stop_q;
  assign result_o.zero_variance = out_zero_q;

  // Tau never leaves the saturated range.
  a_tau_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (TAU_W'(result_o.tau_value) <= TAU_CAP))
    else $error("tau above cap");

  // Without variance nothing is added to the starting half.
  a_zero_var_tau: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.zero_variance) |->
      (TAU_W'(result_o.tau_value) == TAU_HALF))
    else $error("tau moved without variance");

  // Closing item stops intake: ready must fall once it is accepted.
  a_close_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready && sample_i.is_last) |=> !sample_i.ready)
    else $error("intake open after closing item");

endmodule

// ===== tb/sv/integrated_autocorrelation_time_unit_test.sv =====
// Self-checking testbench for integrated_autocorrelation_time_unit: loads sample series,
// predicts tau, stop lag and zero-variance flag in exact integer arithmetic and checks results.
// Depends on iat_pkg, iat_sample_if and iat_result_if.
module integrated_autocorrelation_time_unit_test;
  import iat_pkg::*;

  localparam int WATCHDOG_LIMIT = 1500000;
  localparam int HOLD_CYCLES    = 3000;
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_FACTOR = APB_ADDR_W'(0);

  typedef enum int {SER_NOISE, SER_SMALL, SER_WALK, SER_CONST, SER_ALT} series_kind_e;

  typedef struct {
    logic [TAU_OUT_W-1:0] tau;
    logic [STOP_W-1:0]    stop;
    logic                 zero_var;
  } tau_result_t;

  // Tracks the series being loaded and the results it must produce.
  class TauScoreboard;
    logic [31:0]   series[$];
    longint        series_sum;
    logic [3:0]    window_factor;
    tau_result_t   pending[$];
    int            errors;

    function new();
      window_factor = WF_RESET;
      series_sum    = 0;
      errors        = 0;
    endfunction

    function tau_result_t compute_tau();
      tau_result_t        r;
      int                 n;
      longint             mean;
      longint             dev[];
      logic signed [127:0] a0, at, x, y;
      logic [127:0]       num, den, quo;
      longint unsigned    tau;
      int                 stop;
      bit                 var_ok;
      n    = series.size();
      mean = (series_sum >= 0) ? series_sum / n : -((-series_sum + n - 1) / n);
      dev  = new[n];
      for (int i = 0; i < n; i++) dev[i] = longint'($signed(series[i])) - mean;
      a0 = 0;
      for (int i = 0; i < n; i++) begin
        x = dev[i];
        a0 += x * x;
      end
      var_ok = (a0 > 0);
      tau    = 64'd32768;
      stop   = 0;
      for (int t = 1; t < n / 2; t++) begin
        at = 0;
        for (int i = 0; i + t < n; i++) begin
          x = dev[i];
          y = dev[i + t];
          at += x * y;
        end
        stop = t;
        if (at <= 0 || !var_ok) break;
        num = 128'(at) * 128'(n) * 128'(65536);
        den = 128'(a0) * 128'(n - t);
        quo = num / den;
        tau += quo[63:0];
        if ((64'(t) << 16) > 64'(window_factor) * tau) break;
      end
      r.tau      = (tau > 64'd33554432) ? TAU_OUT_W'(33554432) : TAU_OUT_W'(tau);
      r.stop     = (stop > 511) ? STOP_W'(511) : STOP_W'(stop);
      r.zero_var = !var_ok;
      return r;
    endfunction

    // Note an accepted sample; a closing sample queues the expected result.
    function void note_sample(logic [31:0] value, logic last);
      if (series.size() < MAX_SAMPLES) begin
        series = {series, value};
        series_sum += longint'($signed(value));
      end
      if (last) begin
        pending = {pending, compute_tau()};
        series.delete();
        series_sum = 0;
      end
    endfunction

    function void check_result(logic [TAU_OUT_W-1:0] tau, logic [STOP_W-1:0] stop, logic zv);
      tau_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result tau_value=%0d stop_lag=%0d", tau, stop);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (tau !== e.tau) begin
        $error("tau_value expected %0d actual %0d", e.tau, tau);
        errors++;
      end
      if (stop !== e.stop) begin
        $error("stop_lag expected %0d actual %0d", e.stop, stop);
        errors++;
      end
      if (zv !== e.zero_var) begin
        $error("zero_variance expected %0d actual %0d", e.zero_var, zv);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  iat_sample_if sample_ch();
  iat_result_if result_ch();

  integrated_autocorrelation_time_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch.sink),
    .result_o (result_ch.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  TauScoreboard tau_board;
  int           send_gap_max;
  int           recv_stall_max;
  bit           hold_request;
  int           idle_cycles;
  int           items_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: count cycles in which no item moves on either channel.
  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("integrated_autocorrelation_time_unit verification failed");
      $finish;
    end
  end

  // Result side: stall at random, hold off for a long stretch on request, check each item.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        stall = $urandom_range(recv_stall_max, 0);
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      result_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_ch.valid) @(posedge clk_i);
      tau_board.check_result(result_ch.tau_value, result_ch.stop_lag, result_ch.zero_variance);
    end
  end

  // Offer one sample; called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_sample(logic [31:0] value, logic last);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_value <= value;
    sample_ch.is_last      <= last;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    tau_board.note_sample(value, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_series(series_kind_e kind, int len);
    logic [31:0] value, step;
    value = $urandom();
    step  = $urandom_range(4096, 1);
    for (int i = 0; i < len; i++) begin
      case (kind)
        SER_NOISE: value = $urandom();
        SER_SMALL: value = 32'($signed($urandom_range(512, 0)) - 256);
        SER_WALK:  value = value + 32'($signed($urandom_range(2 * step, 0)) - $signed(step));
        SER_CONST: ;
        SER_ALT:   value = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
      send_sample(value, i == len - 1);
    end
  endtask

  // Drain all results, let the block settle, then write window_factor.
  task automatic set_window_factor(logic [3:0] wf);
    sample_ch.valid <= 1'b0;
    while (tau_board.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW_FACTOR;
    pwdata  <= APB_DATA_W'(wf);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tau_board.window_factor = wf;
    @(negedge clk_i);
  endtask

  task automatic random_series();
    int           pick, len;
    series_kind_e kind;
    pick = $urandom_range(99, 0);
    kind = (pick < 45) ? SER_WALK : (pick < 75) ? SER_NOISE : (pick < 90) ? SER_SMALL :
           (pick < 96) ? SER_CONST : SER_ALT;
    len  = ($urandom_range(39, 0) == 0) ? $urandom_range(200, 60) : $urandom_range(40, 1);
    send_series(kind, len);
  endtask

  initial begin
    logic [3:0] wf_plan[6] = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd9, 4'd15};
    tau_board              = new();
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.sample_value = '0;
    sample_ch.is_last      = 1'b0;
    send_gap_max           = 0;
    recv_stall_max         = 0;
    hold_request           = 1'b0;
    idle_cycles            = 0;
    items_sent             = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: single sample, short series, extremes, constant, random walk.
    send_sample(32'h8000_0000, 1'b1);
    send_series(SER_NOISE, 2);
    send_series(SER_NOISE, 3);
    send_series(SER_WALK, 4);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_series(SER_CONST, 6);
    send_series(SER_WALK, 8);

    // Fill the store past its depth; the closing sample is dropped but still closes.
    send_series(SER_ALT, MAX_SAMPLES + 6);

    // Random phases over several window factors, with and without idling.
    for (int p = 0; p < 6; p++) begin
      set_window_factor(wf_plan[p]);
      send_gap_max   = (p % 2) ? 17 : 0;
      recv_stall_max = (p % 3 == 1) ? 0 : 17;
      if (p == 2) hold_request = 1'b1;
      for (int s = 0; s < 4; s++) random_series();
    end
    set_window_factor(4'($urandom_range(15, 1)));
    send_gap_max   = 17;
    recv_stall_max = 17;
    while (items_sent < 1700) random_series();
    sample_ch.valid <= 1'b0;

    while (tau_board.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (tau_board.errors == 0) begin
      $display("integrated_autocorrelation_time_unit verification clean");
    end else begin
      $display("integrated_autocorrelation_time_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/iat_pkg.sv
src/iat_sample_if.sv
src/iat_result_if.sv
src/iat_ratio.sv
src/iat_datapath.sv
src/iat_ctrl.sv
src/integrated_autocorrelation_time_unit.sv
tb/sv/integrated_autocorrelation_time_unit_test.sv
